>>> rtl/core/uvlt_pkg.sv
package uvlt_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int KEY_W   = 32;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 5;
    localparam int OUT_W   = 16;

    // request kinds (s_axis_tuser)
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic              load;      // capture request, restart scan
        logic              scan_en;   // advance the search pipeline
        logic              ins_wr;    // append key at slot count
        logic              rm_rd;     // read last entry
        logic              rm_wr;     // move last entry into the hit slot
        logic              out_load;  // load the result register
        logic [STAT_W-1:0] status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             empty;
        logic             scan_done;
        logic             hit;
        logic             out_busy;
    } t_sts;

endpackage

>>> rtl/core/uvlt_ctrl.sv
module uvlt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  uvlt_pkg::t_sts  i_sts,
    output uvlt_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_RM_RD  = 3'd3;
    localparam logic [2:0] S_RM_WR  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [uvlt_pkg::STAT_W-1:0]  r_status;
    logic [uvlt_pkg::STAT_W-1:0]  n_status;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd        = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_sts.req)
                    uvlt_pkg::REQ_INSERT: begin
                        if (i_sts.full) begin
                            n_status = uvlt_pkg::ST_FULL;
                            n_state  = S_RESULT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    uvlt_pkg::REQ_SEARCH: begin
                        n_state = S_SCAN;
                    end
                    uvlt_pkg::REQ_REMOVE: begin
                        if (i_sts.empty) begin
                            n_status = uvlt_pkg::ST_EMPTY;
                            n_state  = S_RESULT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_status = uvlt_pkg::ST_ABSENT;
                        n_state  = S_RESULT;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_RESULT;
                    case (i_sts.req)
                        uvlt_pkg::REQ_INSERT: begin
                            if (i_sts.hit) begin
                                n_status = uvlt_pkg::ST_PRESENT;
                            end else begin
                                o_cmd.ins_wr = 1'b1;
                                n_status     = uvlt_pkg::ST_DONE;
                            end
                        end
                        uvlt_pkg::REQ_SEARCH: begin
                            n_status = i_sts.hit ? uvlt_pkg::ST_DONE : uvlt_pkg::ST_ABSENT;
                        end
                        uvlt_pkg::REQ_REMOVE: begin
                            if (i_sts.hit) begin
                                n_state = S_RM_RD;
                            end else begin
                                n_status = uvlt_pkg::ST_ABSENT;
                            end
                        end
                        default: begin
                            n_status = uvlt_pkg::ST_ABSENT;
                        end
                    endcase
                end
            end
            S_RM_RD: begin
                o_cmd.rm_rd = 1'b1;
                n_state     = S_RM_WR;
            end
            S_RM_WR: begin
                o_cmd.rm_wr = 1'b1;
                n_status    = uvlt_pkg::ST_DONE;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= uvlt_pkg::ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

>>> rtl/core/uvlt_dp.sv
module uvlt_dp #(
    parameter int CAPACITY = uvlt_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  uvlt_pkg::t_cmd               i_cmd,
    output uvlt_pkg::t_sts               o_sts,
    input  logic [uvlt_pkg::REQ_W-1:0]   i_req,
    input  logic [uvlt_pkg::KEY_W-1:0]   i_key,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [uvlt_pkg::OUT_W-1:0]   o_out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [uvlt_pkg::KEY_W-1:0]  mem [CAPACITY];

    logic [uvlt_pkg::REQ_W-1:0]  r_req;
    logic [uvlt_pkg::KEY_W-1:0]  r_key;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_rd_idx;
    logic [IW-1:0]               r_cmp_idx;
    logic                        r_cmp_vld;
    logic                        r_hit;
    logic [IW-1:0]               r_slot;
    logic [uvlt_pkg::KEY_W-1:0]  r_rdata;
    logic                        r_out_vld;
    logic [uvlt_pkg::OUT_W-1:0]  r_out_data;

    logic                        hit_now;
    logic                        issue;
    logic                        rd_en;
    logic [IW-1:0]               raddr;
    logic [IW-1:0]               last_idx;
    logic                        wr_en;
    logic [IW-1:0]               waddr;
    logic [uvlt_pkg::KEY_W-1:0]  wdata;
    logic [uvlt_pkg::POS_W-1:0]  res_pos;

    // scan pipeline: read slot, compare in the next cycle
    assign hit_now  = i_cmd.scan_en && r_cmp_vld && !r_hit && (r_rdata == r_key);
    assign issue    = i_cmd.scan_en && !r_hit && !hit_now && (r_rd_idx < r_count);
    assign last_idx = IW'(r_count - CW'(1));
    assign rd_en    = issue || i_cmd.rm_rd;
    assign raddr    = i_cmd.rm_rd ? last_idx : r_rd_idx[IW-1:0];
    assign wr_en    = i_cmd.ins_wr || i_cmd.rm_wr;
    assign waddr    = i_cmd.ins_wr ? IW'(r_count) : r_slot;
    assign wdata    = i_cmd.ins_wr ? r_key : r_rdata;
    assign res_pos  = (i_cmd.status == uvlt_pkg::ST_DONE) ? uvlt_pkg::POS_W'(r_slot) : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end else if (i_cmd.scan_en) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.ins_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.rm_wr) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_key <= i_key;
        end
        if (issue) begin
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
        if (hit_now) begin
            r_slot <= r_cmp_idx;
        end else if (i_cmd.ins_wr) begin
            r_slot <= IW'(r_count);
        end
        if (i_cmd.out_load) begin
            r_out_data <= {4'b0000, uvlt_pkg::CNT_W'(r_count), res_pos, i_cmd.status};
        end
    end

    assign o_sts.req       = r_req;
    assign o_sts.full      = (r_count == CW'(CAPACITY));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_done = r_hit || (!r_cmp_vld && (r_rd_idx >= r_count));
    assign o_sts.hit       = r_hit;
    assign o_sts.out_busy  = r_out_vld && !i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/core/unique_value_list_table_unit.sv
// Unordered table of up to CAPACITY distinct 32-bit keys. Each transfer on
// the s_axis side is one request (tuser: 0 insert, 1 search, 2 remove; tdata:
// key) and yields exactly one transfer on the m_axis side carrying status,
// position and the entry count after the request. One request is worked on
// at a time; its duration is set by the linear scan through the entry
// memory, which reads one slot per cycle until a hit, with the compare in
// the cycle after the read. A remove that hits then reads the last entry
// and writes it into the freed slot. The next request is taken while a
// finished result still waits in the output register. Entries need no
// clearing after reset: only slots below the count are ever read.
module unique_value_list_table_unit #(
    parameter int CAPACITY = uvlt_pkg::CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] key
    input  logic [1:0]   s_axis_tuser,   // [1:0] req_type
    // result side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata    // [2:0] status, [6:3] position,
                                         // [11:7] entry_count, [15:12] zero
);

    uvlt_pkg::t_cmd cmd;
    uvlt_pkg::t_sts sts;

    // sequencing: check, optional scan, optional swap, result
    uvlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // entry memory, count, scan pipeline and output register
    uvlt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (s_axis_tuser),
        .i_key       (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> rtl/core/uvlt_chk.sv
module uvlt_chk #(
    parameter int CAPACITY = uvlt_pkg::CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [15:0]  m_axis_tdata
);

    logic [2:0] res_status;
    logic [3:0] res_pos;
    logic [4:0] res_cnt;

    assign res_status = m_axis_tdata[2:0];
    assign res_pos    = m_axis_tdata[6:3];
    assign res_cnt    = m_axis_tdata[11:7];

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // position only meaningful on success
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res_status != uvlt_pkg::ST_DONE) |-> res_pos == 4'd0)
        else $error("nonzero position on failed request");

    // a full refusal reports a full table
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res_status == uvlt_pkg::ST_FULL) |-> res_cnt == 5'(CAPACITY))
        else $error("full status with count below capacity");

    // an empty refusal reports an empty table
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res_status == uvlt_pkg::ST_EMPTY) |-> res_cnt == 5'd0)
        else $error("empty status with nonzero count");

    // requests are never taken back to back
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

endmodule

bind unique_value_list_table_unit uvlt_chk #(
    .CAPACITY (CAPACITY)
) u_uvlt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
